// File: rtl/bibf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibf_pkg
// Shared types, constants and codes of the boot image block framer.
// ----------------------------------------------------------------------------
package bibf_pkg;

  // Image geometry
  localparam int WordsPerLine    = 8;
  localparam int QuadGroupLines  = 4;
  localparam int PairGroupLines  = 2;
  localparam int TailWindowLines = 4;

  localparam int BufWords    = QuadGroupLines * WordsPerLine;
  localparam int BufIdxW     = $clog2(BufWords);
  localparam int SlotW       = $clog2(QuadGroupLines);
  localparam int BufLinesW   = $clog2(QuadGroupLines + 1);
  localparam int HeaderHalves = 2;
  localparam int PairResults = HeaderHalves + PairGroupLines * WordsPerLine;
  localparam int QuadResults = HeaderHalves + QuadGroupLines * WordsPerLine;
  localparam int PosW        = $clog2(QuadResults);

  localparam logic [31:0] PairOffset = 32'h0000_0010;
  localparam logic [31:0] QuadOffset = 32'h0000_0030;

  localparam int LineCntW = 24;

  // Command queue between front and back
  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = $clog2(CmdDepth);
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TOTAL_LINES = 2'd0,
    REG_PAIR_BASE   = 2'd1,
    REG_QUAD_BASE   = 2'd2
  } cfg_reg_e;

  // What the back end does with a line after storing it
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PAIR = 2'd1,
    ACT_QUAD = 2'd2,
    ACT_ERR  = 2'd3
  } act_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic [31:0] line_address;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;
    logic [15:0] word5;
    logic [15:0] word6;
    logic [15:0] word7;
  } in_item_t;

  typedef struct packed {
    logic [15:0] half;
    logic        is_header;
    logic        status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic                              slot_vld;
    logic [SlotW-1:0]                  slot;
    logic [WordsPerLine-1:0][15:0]     words;
    act_e                              action;
    logic [31:0]                       header;
  } cmd_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/bibf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibf_front
// Line counter and classifier: holds configuration, decides per line where
// its words go and which block, if any, it closes, and posts a command.
// ----------------------------------------------------------------------------
module bibf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                push_i,
  input  bibf_pkg::in_item_t  in_item_i,
  input  bibf_pkg::q_stat_t   q_stat_i,
  output logic                cmd_push_o,
  output bibf_pkg::cmd_t      cmd_o
);

  logic [bibf_pkg::LineCntW-1:0]  total_q, total_d;
  logic [31:0]                    pair_base_q, pair_base_d;
  logic [31:0]                    quad_base_q, quad_base_d;
  logic [bibf_pkg::LineCntW-1:0]  line_cnt_q, line_cnt_d;
  logic [bibf_pkg::BufLinesW-1:0] buffered_q, buffered_d;
  logic                           err_q, err_d;

  logic [bibf_pkg::LineCntW-1:0]  cnt_next;
  logic                           accept;
  logic                           tail;
  logic                           pair_due;
  logic                           quad_due;
  logic [31:0]                    offset;
  logic [31:0]                    base;
  logic                           slot_vld;
  bibf_pkg::act_e                 action;

  // Classify the incoming line
  always_comb begin
    accept   = push_i && !q_stat_i.full;
    cnt_next = line_cnt_q + bibf_pkg::LineCntW'(1);
    tail     = (total_q >= bibf_pkg::LineCntW'(bibf_pkg::TailWindowLines)) &&
               (cnt_next > (total_q - bibf_pkg::LineCntW'(bibf_pkg::TailWindowLines)));
    pair_due = tail && ((cnt_next % bibf_pkg::PairGroupLines) == '0);
    quad_due = (cnt_next % bibf_pkg::QuadGroupLines) == '0;
    slot_vld = buffered_q < bibf_pkg::BufLinesW'(bibf_pkg::QuadGroupLines);

    offset = bibf_pkg::QuadOffset;
    base   = quad_base_q;
    action = bibf_pkg::ACT_NONE;
    priority if (pair_due) begin
      offset = bibf_pkg::PairOffset;
      base   = pair_base_q;
      action = bibf_pkg::ACT_PAIR;
    end else if (quad_due) begin
      action = bibf_pkg::ACT_QUAD;
    end
    if (action != bibf_pkg::ACT_NONE && in_item_i.line_address < offset) begin
      action = bibf_pkg::ACT_ERR;
    end
  end

  // Build the command for the back end
  always_comb begin
    cmd_push_o     = accept && !err_q;
    cmd_o.slot_vld = slot_vld;
    cmd_o.slot     = buffered_q[bibf_pkg::SlotW-1:0];
    cmd_o.words[0] = in_item_i.word0;
    cmd_o.words[1] = in_item_i.word1;
    cmd_o.words[2] = in_item_i.word2;
    cmd_o.words[3] = in_item_i.word3;
    cmd_o.words[4] = in_item_i.word4;
    cmd_o.words[5] = in_item_i.word5;
    cmd_o.words[6] = in_item_i.word6;
    cmd_o.words[7] = in_item_i.word7;
    cmd_o.action   = action;
    cmd_o.header   = base + in_item_i.line_address - offset;
  end

  // Next state: a configuration write takes priority over line bookkeeping
  always_comb begin
    total_d     = total_q;
    pair_base_d = pair_base_q;
    quad_base_d = quad_base_q;
    line_cnt_d  = line_cnt_q;
    buffered_d  = buffered_q;
    err_d       = err_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bibf_pkg::REG_TOTAL_LINES: begin
          total_d    = cfg_wdata_i[bibf_pkg::LineCntW-1:0];
          line_cnt_d = '0;
          buffered_d = '0;
          err_d      = 1'b0;
        end
        bibf_pkg::REG_PAIR_BASE: pair_base_d = cfg_wdata_i;
        bibf_pkg::REG_QUAD_BASE: quad_base_d = cfg_wdata_i;
        default: ;
      endcase
    end else if (cmd_push_o) begin
      line_cnt_d = cnt_next;
      if (action != bibf_pkg::ACT_NONE) begin
        buffered_d = '0;
      end else if (slot_vld) begin
        buffered_d = buffered_q + bibf_pkg::BufLinesW'(1);
      end
      if (action == bibf_pkg::ACT_ERR) begin
        err_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      pair_base_q <= '0;
      quad_base_q <= '0;
      line_cnt_q  <= '0;
      buffered_q  <= '0;
      err_q       <= 1'b0;
    end else begin
      total_q     <= total_d;
      pair_base_q <= pair_base_d;
      quad_base_q <= quad_base_d;
      line_cnt_q  <= line_cnt_d;
      buffered_q  <= buffered_d;
      err_q       <= err_d;
    end
  end

  // The buffer never claims more than one group of lines
  a_buffered_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buffered_q <= bibf_pkg::BufLinesW'(bibf_pkg::QuadGroupLines))
    else $error("buffered line count out of range");

  // Sticky error: once set, no further command leaves until a restart
  a_err_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !cmd_push_o)
    else $error("command posted while error is set");

endmodule

// File: rtl/bibf_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibf_cmd_fifo
// Short command queue that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module bibf_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bibf_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output bibf_pkg::cmd_t     cmd_o,
  output bibf_pkg::q_stat_t  stat_o
);

  bibf_pkg::cmd_t                mem_q [bibf_pkg::CmdDepth];
  logic [bibf_pkg::CmdPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [bibf_pkg::CmdPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [bibf_pkg::CmdCntW-1:0]  cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [bibf_pkg::CmdPtrW-1:0] ptr_inc(
    input logic [bibf_pkg::CmdPtrW-1:0] ptr
  );
    logic [bibf_pkg::CmdPtrW-1:0] nxt;
    if (ptr == bibf_pkg::CmdPtrW'(bibf_pkg::CmdDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + bibf_pkg::CmdPtrW'(1);
    end
    return nxt;
  endfunction

  // Advance pointers and occupancy
  always_comb begin
    stat_o.full  = cnt_q == bibf_pkg::CmdCntW'(bibf_pkg::CmdDepth);
    stat_o.empty = cnt_q == '0;
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    wr_ptr_d     = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d     = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d        = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + bibf_pkg::CmdCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - bibf_pkg::CmdCntW'(1);
    end
    cmd_o = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the request payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bibf_pkg::CmdCntW'(bibf_pkg::CmdDepth))
    else $error("command queue overfilled");

endmodule

// File: rtl/bibf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibf_back
// Emitter: owns the word buffer, stores each line, and streams header and
// data halfwords of each due block, or one error result, into a one-entry result register.
// ----------------------------------------------------------------------------
module bibf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bibf_pkg::cmd_t       cmd_i,
  input  bibf_pkg::q_stat_t    q_stat_i,
  output logic                 cmd_pop_o,
  input  logic                 pop,
  output logic                 empty,
  output bibf_pkg::out_item_t  out_item_o
);

  bibf_pkg::bk_state_e        state_q, state_d;
  logic [bibf_pkg::PosW-1:0]  pos_q, pos_d;
  logic [bibf_pkg::PosW-1:0]  last_pos_q;
  logic                       err_q;
  logic [31:0]                hdr_q;
  logic [15:0]                buf_q [bibf_pkg::BufWords];
  bibf_pkg::out_item_t        out_q, res;
  logic                       out_vld_q, out_vld_d;

  logic                         out_free;
  logic                         load;
  logic [bibf_pkg::BufIdxW-1:0] widx;

  // Pick the result for the current position
  always_comb begin
    widx = bibf_pkg::BufIdxW'(pos_q - bibf_pkg::PosW'(bibf_pkg::HeaderHalves));
    res  = '0;
    priority if (err_q) begin
      res.status = 1'b1;
      res.last   = 1'b1;
    end else if (pos_q == '0) begin
      res.half      = hdr_q[31:16];
      res.is_header = 1'b1;
    end else if (pos_q == bibf_pkg::PosW'(1)) begin
      res.half      = hdr_q[15:0];
      res.is_header = 1'b1;
    end else begin
      res.half = buf_q[widx];
      res.last = pos_q == last_pos_q;
    end
  end

  // Sequencer: take a request, then emit its results one per free slot
  always_comb begin
    out_free  = !out_vld_q || pop;
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    state_d   = state_q;
    pos_d     = pos_q;
    unique case (state_q)
      bibf_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          cmd_pop_o = 1'b1;
          pos_d     = '0;
          if (cmd_i.action != bibf_pkg::ACT_NONE) begin
            state_d = bibf_pkg::BK_EMIT;
          end
        end
      end
      bibf_pkg::BK_EMIT: begin
        if (out_free) begin
          load  = 1'b1;
          pos_d = pos_q + bibf_pkg::PosW'(1);
          if (pos_q == last_pos_q) begin
            state_d = bibf_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = bibf_pkg::BK_IDLE;
    endcase
    out_vld_d = load ? 1'b1 : (pop ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bibf_pkg::BK_IDLE;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Latch block parameters and store the line's words
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      hdr_q <= cmd_i.header;
      err_q <= cmd_i.action == bibf_pkg::ACT_ERR;
      unique case (cmd_i.action)
        bibf_pkg::ACT_PAIR: last_pos_q <= bibf_pkg::PosW'(bibf_pkg::PairResults - 1);
        bibf_pkg::ACT_QUAD: last_pos_q <= bibf_pkg::PosW'(bibf_pkg::QuadResults - 1);
        default:            last_pos_q <= '0;
      endcase
      if (cmd_i.slot_vld) begin
        for (int i = 0; i < bibf_pkg::WordsPerLine; i++) begin
          buf_q[bibf_pkg::BufIdxW'(int'(cmd_i.slot) * bibf_pkg::WordsPerLine + i)]
            <= cmd_i.words[i];
        end
      end
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bibf_pkg::BK_EMIT) |-> (pos_q <= last_pos_q))
    else $error("emit position past end of block");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bibf_pkg::BK_EMIT && err_q) |-> (last_pos_q == '0))
    else $error("error block longer than one result");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res.last) |=> (state_q == bibf_pkg::BK_IDLE))
    else $error("emitter kept running after last result");

endmodule

// File: rtl/boot_image_block_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_image_block_framer
// Frames boot image lines into pair and quad blocks of big-endian halfwords.
//
//   channel  direction  handshake          payload
//   input    in         push / full        in_item_i  (address, 8 words)
//   result   out        empty / pop        out_item_o (half, flags)
//   config   in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// A line that closes no block is only stored by the back end; a pair block
// line also yields 18 results and a quad block line 34, emitted at one
// halfword per cycle while the result register is free.
// The front takes one line per cycle while the two-entry command queue has
// room, so it keeps accepting while results wait on the output register.
// Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module boot_image_block_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  bibf_pkg::in_item_t   in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output bibf_pkg::out_item_t  out_item_o
);

  bibf_pkg::cmd_t     front_cmd;
  bibf_pkg::cmd_t     back_cmd;
  bibf_pkg::q_stat_t  q_stat;
  logic               cmd_push;
  logic               cmd_pop;

  bibf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .q_stat_i    (q_stat),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  bibf_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (front_cmd),
    .pop_i  (cmd_pop),
    .cmd_o  (back_cmd),
    .stat_o (q_stat)
  );

  bibf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .q_stat_i   (q_stat),
    .cmd_pop_o  (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

  assign full = q_stat.full;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boot image block framer. A driver feeds image
// lines through the push/full queue and programs the job registers while the
// block is idle; every accepted line runs through a behavioral copy of the
// framer that queues the halfwords it must emit. A monitor pops results at a
// random rate and compares each one field by field with the oldest expected
// halfword. Directed jobs cover header wrap, offset boundaries, pair and quad
// blocks, underflow with its sticky error and dropped partial groups; random
// jobs follow under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 5;
  localparam int DrainCycles   = 64;
  localparam int WatchdogLimit = 3000;
  localparam int RandomLines   = 224;

  typedef struct {
    bibf_pkg::cfg_reg_e idx;
    logic [31:0]        data;
  } reg_write_t;

  // Clock, reset and block ports
  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  bibf_pkg::cfg_reg_e   cfg_idx   = bibf_pkg::REG_TOTAL_LINES;
  logic [31:0]          cfg_wdata = '0;
  logic                 push      = 1'b0;
  logic                 full;
  bibf_pkg::in_item_t   in_item   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  bibf_pkg::out_item_t  out_item;

  // Stimulus queues and idling control
  bibf_pkg::in_item_t   image_lines [$];
  reg_write_t           reg_writes [$];
  bibf_pkg::out_item_t  due_halves [$];
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;

  // Shadow of the framer's job registers and state
  logic [23:0] job_lines   = '0;
  logic [31:0] pair_base_r = '0;
  logic [31:0] quad_base_r = '0;
  logic [23:0] line_no     = '0;
  logic [15:0] word_buf [bibf_pkg::BufWords];
  int unsigned buf_lines   = 0;
  bit          job_failed  = 1'b0;

  // Run statistics
  int unsigned framed_lines    = 0;
  int unsigned ignored_lines   = 0;
  int unsigned pair_blocks     = 0;
  int unsigned quad_blocks     = 0;
  int unsigned underflows      = 0;
  int unsigned results_checked = 0;
  int unsigned jobs            = 0;
  int unsigned fail_cnt        = 0;
  int unsigned idle_cycles     = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  boot_image_block_framer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item)
  );

  // Apply one register write to the shadow state
  function automatic void apply_reg(bibf_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      bibf_pkg::REG_TOTAL_LINES: begin
        job_lines  = data[23:0];
        line_no    = '0;
        buf_lines  = 0;
        job_failed = 1'b0;
      end
      bibf_pkg::REG_PAIR_BASE: pair_base_r = data;
      bibf_pkg::REG_QUAD_BASE: quad_base_r = data;
      default: ;
    endcase
  endfunction

  // Store one line and queue the halfwords of the block it closes, if any
  function automatic void frame_line(input bibf_pkg::in_item_t line);
    logic [15:0] w [bibf_pkg::WordsPerLine];
    int unsigned num, nwords;
    logic [31:0] base, offset, hdr;
    bit          tail, is_pair;
    if (job_failed) begin
      ignored_lines++;
      return;
    end
    framed_lines++;
    w = '{line.word0, line.word1, line.word2, line.word3,
          line.word4, line.word5, line.word6, line.word7};
    line_no = line_no + 24'd1;
    num     = 32'(line_no);
    if (buf_lines < bibf_pkg::QuadGroupLines) begin
      for (int i = 0; i < bibf_pkg::WordsPerLine; i++) begin
        word_buf[buf_lines * bibf_pkg::WordsPerLine + i] = w[i];
      end
      buf_lines++;
    end
    tail = (job_lines >= bibf_pkg::TailWindowLines) &&
           (num > job_lines - bibf_pkg::TailWindowLines);
    if (tail && num % bibf_pkg::PairGroupLines == 0) begin
      is_pair = 1'b1;
      base    = pair_base_r;
      offset  = bibf_pkg::PairOffset;
      nwords  = bibf_pkg::PairGroupLines * bibf_pkg::WordsPerLine;
    end else if (num % bibf_pkg::QuadGroupLines == 0) begin
      is_pair = 1'b0;
      base    = quad_base_r;
      offset  = bibf_pkg::QuadOffset;
      nwords  = bibf_pkg::QuadGroupLines * bibf_pkg::WordsPerLine;
    end else begin
      return;
    end
    buf_lines = 0;
    // Address below the header offset: one error result, then go sticky
    if (line.line_address < offset) begin
      underflows++;
      job_failed = 1'b1;
      due_halves.push_back('{half: 16'h0000, is_header: 1'b0, status: 1'b1, last: 1'b1});
      return;
    end
    if (is_pair) pair_blocks++;
    else quad_blocks++;
    hdr = base + line.line_address - offset;
    due_halves.push_back('{half: hdr[31:16], is_header: 1'b1, status: 1'b0, last: 1'b0});
    due_halves.push_back('{half: hdr[15:0], is_header: 1'b1, status: 1'b0, last: 1'b0});
    for (int i = 0; i < nwords; i++) begin
      due_halves.push_back('{half: word_buf[i], is_header: 1'b0, status: 1'b0,
                             last: (i == nwords - 1)});
    end
  endfunction

  // Drive register writes and line requests; track every accepted request
  always @(posedge clk_i) begin : line_driver
    bit took;
    if (rst_ni) begin
      if (cfg_we) apply_reg(cfg_idx, cfg_wdata);
      if (reg_writes.size() != 0) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= reg_writes[0].idx;
        cfg_wdata <= reg_writes[0].data;
        void'(reg_writes.pop_front());
      end else begin
        cfg_we <= 1'b0;
      end
      took = push && !full;
      if (took) begin
        frame_line(in_item);
        void'(image_lines.pop_front());
      end
      // Hold a pending request; otherwise offer the next line or idle
      if (!push || took) begin
        if (image_lines.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          in_item <= image_lines[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Pop results at a random rate and compare with the oldest expected halfword
  always @(posedge clk_i) begin : result_monitor
    bibf_pkg::out_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_halves.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got half=%h hdr=%b st=%b last=%b",
                   $time, out_item.half, out_item.is_header, out_item.status, out_item.last);
          fail_cnt++;
        end else begin
          want = due_halves.pop_front();
          results_checked++;
          if (out_item.half !== want.half) begin
            $display("%0t ns: half expected %h got %h", $time, want.half, out_item.half);
            fail_cnt++;
          end
          if (out_item.is_header !== want.is_header) begin
            $display("%0t ns: is_header expected %b got %b", $time, want.is_header,
                     out_item.is_header);
            fail_cnt++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t ns: status expected %b got %b", $time, want.status, out_item.status);
            fail_cnt++;
          end
          if (out_item.last !== want.last) begin
            $display("%0t ns: last expected %b got %b", $time, want.last, out_item.last);
            fail_cnt++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when no request moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
        $display("%0t ns: watchdog, no request moved in %0d cycles", $time, WatchdogLimit);
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic bibf_pkg::in_item_t make_line(logic [31:0] addr);
    return {addr, $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Wait until all lines are taken, all results are out and the back end is quiet
  task automatic settle();
    while (image_lines.size() != 0 || push || due_halves.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(bibf_pkg::cfg_reg_e idx, logic [31:0] data);
    reg_writes.push_back('{idx: idx, data: data});
    while (reg_writes.size() != 0 || cfg_we) @(negedge clk_i);
  endtask

  task automatic set_job(logic [23:0] lines, logic [31:0] pbase, logic [31:0] qbase);
    write_reg(bibf_pkg::REG_PAIR_BASE, pbase);
    write_reg(bibf_pkg::REG_QUAD_BASE, qbase);
    write_reg(bibf_pkg::REG_TOTAL_LINES, {8'h00, lines});
    jobs++;
  endtask

  // One random job: mostly sequential lines, some noise and low addresses
  task automatic random_job();
    logic [23:0] lines;
    logic [31:0] addr, seq_addr;
    int unsigned pick, n;
    pick = $urandom_range(99);
    if (pick < 8) lines = 24'($urandom_range(0, 3));
    else if (pick < 14) lines = 24'hFF_FFFF;
    else if (pick < 18) lines = 24'($urandom());
    else lines = 24'($urandom_range(bibf_pkg::TailWindowLines, 24));
    set_job(lines, pick_base(), pick_base());
    if (lines >= bibf_pkg::TailWindowLines && lines <= 24) begin
      n = $urandom_range(lines - 2, lines + 5);
    end else begin
      n = $urandom_range(4, 24);
    end
    seq_addr = $urandom() & 32'hFFFF_FFF0;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 3) addr = $urandom_range(0, 'h2F);
      else if (pick < 12) addr = $urandom();
      else addr = seq_addr;
      seq_addr += 32'h10;
      image_lines.push_back(make_line(addr));
    end
    settle();
  endtask

  initial begin
    int unsigned goal;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Quad blocks without a tail window; header wraps at the top of the space
    set_job(24'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    image_lines.push_back({32'h0000_1000, {bibf_pkg::WordsPerLine{16'h0000}}});
    image_lines.push_back({32'h0000_1010, {bibf_pkg::WordsPerLine{16'hFFFF}}});
    image_lines.push_back(make_line(32'h0000_1020));
    image_lines.push_back(make_line(32'hFFFF_FFFF));
    // Quad line exactly at its offset, then a partial group left behind
    image_lines.push_back(make_line(32'h0000_0000));
    image_lines.push_back(make_line(32'h0000_0010));
    image_lines.push_back(make_line(32'h0000_0020));
    image_lines.push_back(make_line(32'h0000_0030));
    image_lines.push_back(make_line(32'h0000_0040));
    settle();

    // Tail window: pair that drops two lines, pair at the end, pair past the end
    set_job(24'd6, 32'hFFFF_FFFF, 32'h0000_0000);
    for (int k = 1; k <= 8; k++) begin
      if (k == 4) image_lines.push_back(make_line(32'h0000_0010));
      else if (k == 8) image_lines.push_back(make_line(32'hFFFF_FFFF));
      else image_lines.push_back(make_line(32'h0000_2000 + 32'h10 * k));
    end
    settle();

    // Pair underflow, then a line dropped by the sticky error
    write_reg(bibf_pkg::REG_TOTAL_LINES, 32'd6);
    jobs++;
    for (int k = 1; k <= 3; k++) image_lines.push_back(make_line(32'h0000_3000 + 32'h10 * k));
    image_lines.push_back(make_line(32'h0000_000F));
    image_lines.push_back(make_line(32'h0000_3050));
    settle();

    // Short job with no tail window; quad underflow just below the offset
    write_reg(bibf_pkg::REG_TOTAL_LINES, 32'd3);
    jobs++;
    for (int k = 1; k <= 3; k++) image_lines.push_back(make_line(32'h0000_4000 + 32'h10 * k));
    image_lines.push_back(make_line(32'h0000_002F));
    settle();

    // Random jobs under four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      goal = framed_lines + ignored_lines + RandomLines / 4;
      while (framed_lines + ignored_lines < goal) random_job();
    end

    $display("summary: %0d lines in %0d jobs, %0d framed, %0d ignored after an underflow",
             framed_lines + ignored_lines, jobs, framed_lines, ignored_lines);
    $display("summary: %0d pair and %0d quad blocks, %0d underflows, %0d halfwords checked",
             pair_blocks, quad_blocks, underflows, results_checked);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
